/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dro_pkg.sv */
`default_nettype none

package dro_pkg;

  localparam int DRO_CORDIC_STEPS  = 16;
  localparam int DRO_POSITION_BITS = 32;

  localparam int ATAN_ENTRIES = 25;

  // CORDIC datapath width, Q1.30 with headroom for growth and sign.
  localparam int CORD_W = 34;

  // Shared multiplier: unsigned A x B with a registered product.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [17:0] INV_TWO_PI_Q20 = 18'd166886;

  typedef struct packed {
    logic signed [15:0] linear_velocity;
    logic signed [15:0] yaw_rate;
    logic        [31:0] timestamp;
  } dro_in_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [15:0] yaw_rate_out;
  } dro_out_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Round a Q.30 value to Q1.15 (add half, arithmetic shift) and saturate.
  function automatic logic signed [15:0] round_q15(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W-1:0] r;
    logic signed [15:0] q;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) begin
      q = 16'sh7fff;
    end else if (r < -34'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  // Magnitude of a 16-bit signed value; the most negative value maps to 32768.
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] m;
    m = v[15] ? 16'(-v) : 16'(v);
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/dro_mul.sv */
`default_nettype none

module dro_mul
  import dro_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] op_a,
  input  wire logic [MUL_B_W-1:0] op_b,
  output logic      [MUL_P_W-1:0] prod
);

  logic [MUL_P_W-1:0] prod_r;

  // Operands come from the sequencer; the product is registered and available in the cycle after.
  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

/* rtl/dro_cordic.sv */
`default_nettype none

module dro_cordic
  import dro_pkg::*;
#(
  parameter int STEPS = DRO_CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        angle,
  output logic                    done,
  output logic signed [15:0]      cos_q15,
  output logic signed [15:0]      sin_q15
);

  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROT,
    C_FIN
  } cord_state_t;

  cord_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]         step_r, step_nxt;
  logic signed [CORD_W-1:0] x_r, x_nxt;
  logic signed [CORD_W-1:0] y_r, y_nxt;
  logic signed [CORD_W-1:0] z_r, z_nxt;
  logic                     flip_r, flip_nxt;
  logic signed [15:0]       cos_r, cos_nxt;
  logic signed [15:0]       sin_r, sin_nxt;

  logic signed [CORD_W-1:0] dx, dy, at;
  logic                     flip_in;
  logic [31:0]              folded;

  // Angles in the second and third quadrants are moved by a half turn.
  assign flip_in = angle[31] ^ angle[30];
  assign folded  = {angle[31] ^ flip_in, angle[30:0]};

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign at = $signed({2'b00, atan_turn(5'(step_r))});

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    flip_nxt  = flip_r;
    cos_nxt   = cos_r;
    sin_nxt   = sin_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          state_nxt = C_ROT;
          step_nxt  = '0;
          x_nxt     = CORDIC_GAIN_Q30;
          y_nxt     = '0;
          z_nxt     = CORD_W'($signed(folded));
          flip_nxt  = flip_in;
        end
      end
      C_ROT: begin
        if (!z_r[CORD_W-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        if (step_r == CNT_W'(STEPS - 1)) begin
          state_nxt = C_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      C_FIN: begin
        cos_nxt   = round_q15(flip_r ? -x_r : x_r);
        sin_nxt   = round_q15(flip_r ? -y_r : y_r);
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
  end

  assign done    = (state_r == C_FIN);
  assign cos_q15 = cos_r;
  assign sin_q15 = sin_r;

endmodule

`default_nettype wire

/* rtl/dead_reckoning_odometry.sv */
// Dead-reckoning odometry for a differential-drive base.
// Input channel (in_valid, in_stall, in_data): one beat per wheel-speed sample,
// carrying forward speed, yaw rate and a free-running timestamp. The step time
// is the wrapped difference from the previous timestamp (zero after reset).
// Output channel (out_valid, out_stall, out_data): one beat per input beat with
// the new pose, the yaw quaternion, the world-frame velocities and the yaw rate.
// From acceptance to out_valid an item goes through two CORDIC passes (old
// heading for the velocity rotation, new half heading for the quaternion);
// between them seven products go through one shared 33x16 multiplier.
// in_stall is high from acceptance until the result is written to the output
// register, so no new beat is taken while an item is still worked on.
// A waiting result sits in the output register while the next item is worked
// on; if the receiver still stalls when that item is done, the sequencer holds.
// Synchronous active-low reset zeroes pose, heading and the previous timestamp
// and drops out_valid.
`default_nettype none
`include "assert_macros.svh"

module dead_reckoning_odometry
  import dro_pkg::*;
#(
  parameter int CORDIC_STEPS  = DRO_CORDIC_STEPS,
  parameter int POSITION_BITS = DRO_POSITION_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dro_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dro_out_t      out_data
);

  // Position step magnitude fits in 39 bits; keep room for sign and carry.
  localparam int SUM_W     = (POSITION_BITS > 39 ? POSITION_BITS : 39) + 2;
  localparam int ACC_EXT_W = (POSITION_BITS > 32 ? POSITION_BITS : 32);
  localparam int HSUM_W    = 50;
  localparam int HACC_W    = 37;

  localparam logic signed [SUM_W-1:0] POS_MAX =
    {{(SUM_W - POSITION_BITS + 1){1'b0}}, {(POSITION_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
  localparam logic signed [ACC_EXT_W-1:0] OUT_MAX =
    {{(ACC_EXT_W - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_EXT_W-1:0] OUT_MIN = ~OUT_MAX;
  localparam logic signed [HACC_W-1:0] HEAD_MAX = {{(HACC_W - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [HACC_W-1:0] HEAD_MIN = ~HEAD_MAX;

  // Sequencer: one CORDIC pass, seven multiplies with their accumulations,
  // a second CORDIC pass, then hand-off to the output register.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CORD1,
    S_VX,
    S_VY,
    S_PX,
    S_PY,
    S_HP,
    S_HH,
    S_HL,
    S_HA,
    S_HU,
    S_QGO,
    S_QWAIT,
    S_OUT
  } seq_state_t;

  seq_state_t                      state_r, state_nxt;
  logic signed [POSITION_BITS-1:0] pos_x_r, pos_x_nxt;
  logic signed [POSITION_BITS-1:0] pos_y_r, pos_y_nxt;
  logic signed [31:0]              heading_r, heading_nxt;
  logic [31:0]                     prev_r, prev_nxt;
  logic [31:0]                     dt_r, dt_nxt;
  logic signed [15:0]              v_r, v_nxt;
  logic signed [15:0]              w_r, w_nxt;
  logic signed [15:0]              vx_r, vx_nxt;
  logic signed [15:0]              vy_r, vy_nxt;
  logic [32:0]                     p_r, p_nxt;
  logic [48:0]                     hi_r, hi_nxt;
  logic [HSUM_W-1:0]               hsum_r, hsum_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dro_out_t                        out_data_r, out_data_nxt;

  logic                      accept;
  logic                      out_free;
  logic                      cord_start;
  logic [31:0]               cord_angle;
  logic                      cord_done;
  logic signed [15:0]        cord_cos, cord_sin;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_P_W-1:0]        mul_p;

  logic signed [CORD_W-1:0]  vmag, vprod;
  logic [48:0]               pround;
  logic signed [SUM_W-1:0]   pstep, psum;
  logic signed [HACC_W-1:0]  hstep, hacc;

  function automatic logic signed [31:0] clamp_out(
    input logic signed [POSITION_BITS-1:0] a
  );
    logic signed [ACC_EXT_W-1:0] e;
    logic signed [31:0] r;
    e = ACC_EXT_W'(a);
    if (e > OUT_MAX) begin
      r = OUT_MAX[31:0];
    end else if (e < OUT_MIN) begin
      r = OUT_MIN[31:0];
    end else begin
      r = e[31:0];
    end
    return r;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // The first pass rotates by the old heading, the second by half the new one.
  assign cord_start = accept || (state_r == S_QGO);
  assign cord_angle = (state_r == S_IDLE) ? {heading_r[15:0], 16'h0000}
                                          : {heading_r[16:0], 15'h0000};

  dro_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cord_start),
    .angle   (cord_angle),
    .done    (cord_done),
    .cos_q15 (cord_cos),
    .sin_q15 (cord_sin)
  );

  dro_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // Operand selection for the shared multiplier, one product per state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_VX: begin
        mul_a = MUL_A_W'(abs16(v_r));
        mul_b = abs16(cord_cos);
      end
      S_VY: begin
        mul_a = MUL_A_W'(abs16(v_r));
        mul_b = abs16(cord_sin);
      end
      S_PX: begin
        mul_a = MUL_A_W'(dt_r);
        mul_b = abs16(vx_r);
      end
      S_PY: begin
        mul_a = MUL_A_W'(dt_r);
        mul_b = abs16(vy_r);
      end
      S_HP: begin
        mul_a = MUL_A_W'(INV_TWO_PI_Q20);
        mul_b = abs16(w_r);
      end
      S_HH: begin
        mul_a = mul_p[32:0];
        mul_b = dt_r[31:16];
      end
      S_HL: begin
        mul_a = p_r;
        mul_b = dt_r[15:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Signed velocity product, rebuilt from the magnitude product.
  assign vmag = $signed({1'b0, mul_p[32:0]});
  always_comb begin
    if (state_r == S_VY) begin
      vprod = (v_r[15] ^ cord_cos[15]) ? -vmag : vmag;
    end else begin
      vprod = (v_r[15] ^ cord_sin[15]) ? -vmag : vmag;
    end
  end

  // Position step: |v| * dt / 1024 rounded half away from zero, then accumulate.
  assign pround = 49'(mul_p[47:0]) + 49'd512;
  always_comb begin
    if (state_r == S_PY) begin
      pstep = vx_r[15] ? -SUM_W'(pround[48:10]) : SUM_W'(pround[48:10]);
      psum  = SUM_W'(pos_x_r) + pstep;
    end else begin
      pstep = vy_r[15] ? -SUM_W'(pround[48:10]) : SUM_W'(pround[48:10]);
      psum  = SUM_W'(pos_y_r) + pstep;
    end
  end

  // Heading step is the upper half of the rounded 2^-32 scaled product.
  assign hstep = w_r[15] ? -HACC_W'(hsum_r[HSUM_W-1:16]) : HACC_W'(hsum_r[HSUM_W-1:16]);
  assign hacc  = HACC_W'(heading_r) + hstep;

  always_comb begin
    state_nxt     = state_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    heading_nxt   = heading_r;
    prev_nxt      = prev_r;
    dt_nxt        = dt_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    p_nxt         = p_r;
    hi_nxt        = hi_r;
    hsum_nxt      = hsum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt     = in_data.linear_velocity;
          w_nxt     = in_data.yaw_rate;
          dt_nxt    = in_data.timestamp - prev_r;
          prev_nxt  = in_data.timestamp;
          state_nxt = S_CORD1;
        end
      end
      S_CORD1: begin
        if (cord_done) begin
          state_nxt = S_VX;
        end
      end
      S_VX: begin
        state_nxt = S_VY;
      end
      S_VY: begin
        vx_nxt    = round_q15(vprod);
        state_nxt = S_PX;
      end
      S_PX: begin
        vy_nxt    = round_q15(vprod);
        state_nxt = S_PY;
      end
      S_PY: begin
        if (psum > POS_MAX) begin
          pos_x_nxt = POS_MAX[POSITION_BITS-1:0];
        end else if (psum < POS_MIN) begin
          pos_x_nxt = POS_MIN[POSITION_BITS-1:0];
        end else begin
          pos_x_nxt = psum[POSITION_BITS-1:0];
        end
        state_nxt = S_HP;
      end
      S_HP: begin
        if (psum > POS_MAX) begin
          pos_y_nxt = POS_MAX[POSITION_BITS-1:0];
        end else if (psum < POS_MIN) begin
          pos_y_nxt = POS_MIN[POSITION_BITS-1:0];
        end else begin
          pos_y_nxt = psum[POSITION_BITS-1:0];
        end
        state_nxt = S_HH;
      end
      S_HH: begin
        p_nxt     = mul_p[32:0];
        state_nxt = S_HL;
      end
      S_HL: begin
        hi_nxt    = mul_p[48:0];
        state_nxt = S_HA;
      end
      S_HA: begin
        hsum_nxt  = HSUM_W'(hi_r) + HSUM_W'(mul_p[48:16]) + HSUM_W'(32768);
        state_nxt = S_HU;
      end
      S_HU: begin
        if (hacc > HEAD_MAX) begin
          heading_nxt = HEAD_MAX[31:0];
        end else if (hacc < HEAD_MIN) begin
          heading_nxt = HEAD_MIN[31:0];
        end else begin
          heading_nxt = hacc[31:0];
        end
        state_nxt = S_QGO;
      end
      S_QGO: begin
        state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        if (cord_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.position_x   = clamp_out(pos_x_r);
          out_data_nxt.position_y   = clamp_out(pos_y_r);
          out_data_nxt.heading      = heading_r;
          out_data_nxt.quat_z       = cord_sin;
          out_data_nxt.quat_w       = cord_cos;
          out_data_nxt.velocity_x   = vx_r;
          out_data_nxt.velocity_y   = vy_r;
          out_data_nxt.yaw_rate_out = w_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      prev_r      <= prev_nxt;
    end
    dt_r       <= dt_nxt;
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    p_r        <= p_nxt;
    hi_r       <= hi_nxt;
    hsum_r     <= hsum_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted beat keeps the input stalled while its item is worked on.
  `ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "input not stalled after accept")
  // The CORDIC finishes only while the sequencer is waiting for it.
  `ASSERT_IMPL(a_done_in_wait, cord_done, state_r == S_CORD1 || state_r == S_QWAIT, "stray done")
  // A finished item with a free output register always shows up as a valid beat.
  `ASSERT_NEXT(a_result_out, state_r == S_OUT && out_free, out_valid_r && !in_stall, "lost result")

endmodule

`default_nettype wire

/* test/tb_dead_reckoning_odometry.sv */
`timescale 1ns / 100ps

module tb_dead_reckoning_odometry
  import dro_pkg::*;
();

  // Which pose fields of a directed row carry a hand-typed expectation.
  localparam logic [2:0] PIN_NONE = 3'b000;
  localparam logic [2:0] PIN_X    = 3'b001;
  localparam logic [2:0] PIN_Y    = 3'b010;
  localparam logic [2:0] PIN_H    = 3'b100;
  localparam logic [2:0] PIN_XH   = PIN_X | PIN_H;
  localparam logic [2:0] PIN_ALL  = PIN_X | PIN_Y | PIN_H;

  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint TURN_GAIN = 64'sd166886;
  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -WORD_MAX - 1;
  localparam longint ACC_MAX   = (64'sd1 <<< (DRO_POSITION_BITS - 1)) - 1;
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam int     CORDIC_N  =
    (DRO_CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : DRO_CORDIC_STEPS;

  // The drain at the end gives the block time to finish anything still in flight.
  localparam int DRAIN_CYCLES = 60;
  localparam int BEATS_PER_PHASE = 650;

  typedef struct packed {
    logic signed [15:0] vel;
    logic signed [15:0] yaw;
    logic        [31:0] stamp;
    logic        [2:0]  pin;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
  } plan_row_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  dro_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  dro_out_t out_data;

  // Arctangent of 2^-i in units of 2^-32 turn.
  longint atan_step [ATAN_ENTRIES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41
  };

  // Dead-reckoning state as the predictor sees it. Reset is applied once at
  // the start of the run, so these simply start out at zero.
  longint      odo_x = 0;
  longint      odo_y = 0;
  longint      odo_heading = 0;
  logic [31:0] odo_last_time = '0;

  dro_out_t    pending_poses [$];
  int          error_count = 0;
  int          sender_idle_pct = 31;
  int          receiver_idle_pct = 71;
  logic [31:0] last_stamp = '0;

  // The directed plan. The first rows all have a zero step time, so the pose
  // stays at the origin whatever the speeds. Then one radian per second for a
  // second gives 10430 in 2^-16 turn. Stepping the timestamp back by one tick
  // wraps to the longest step possible, which drives the heading into both
  // saturation limits and, at heading zero mod a turn, x into both limits.
  // The later rows turn a quarter turn so that y saturates too, and wander
  // through wraps and mixed signs; those are left to the predictor.
  plan_row_t drive_plan [20] = '{
    '{16'sd0,      16'sd0,      32'd0,          PIN_ALL, 0, 0, 0},
    '{16'sd32767,  16'sd32767,  32'd0,          PIN_ALL, 0, 0, 0},
    '{-16'sd32768, -16'sd32768, 32'd0,          PIN_ALL, 0, 0, 0},
    '{16'sd0,      16'sd4096,   32'd65536,      PIN_ALL, 0, 0, 10430},
    '{16'sd0,      16'sd32767,  32'd65535,      PIN_ALL, 0, 0, 32'sh7fffffff},
    '{16'sd0,      -16'sd32768, 32'd65534,      PIN_ALL, 0, 0, 32'sh80000000},
    '{16'sd32767,  16'sd0,      32'd65533,      PIN_XH, 32'sh7fffffff, 0, 32'sh80000000},
    '{-16'sd32768, 16'sd0,      32'd65532,      PIN_XH, 32'sh80000000, 0, 32'sh80000000},
    '{16'sd0,      16'sd0,      32'd65532,      PIN_XH, 32'sh80000000, 0, 32'sh80000000},
    '{16'sd0,      16'sd4096,   32'd168476,     PIN_NONE, 0, 0, 0},
    '{16'sd32767,  16'sd0,      32'd168475,     PIN_NONE, 0, 0, 0},
    '{-16'sd32768, 16'sd0,      32'd168474,     PIN_NONE, 0, 0, 0},
    '{16'sd1000,   -16'sd1000,  32'hffffffff,   PIN_NONE, 0, 0, 0},
    '{-16'sd1,     16'sd1,      32'd5,          PIN_NONE, 0, 0, 0},
    '{16'sd12345,  -16'sd20000, 32'd65541,      PIN_NONE, 0, 0, 0},
    '{-16'sd20000, 16'sd32767,  32'd68541,      PIN_NONE, 0, 0, 0},
    '{16'sd32767,  -16'sd32768, 32'd68542,      PIN_NONE, 0, 0, 0},
    '{-16'sd32768, 16'sd32767,  32'h80000000,   PIN_NONE, 0, 0, 0},
    '{16'sd16384,  16'sd8192,   32'h80001000,   PIN_NONE, 0, 0, 0},
    '{16'sd21845,  -16'sd21846, 32'h80011000,   PIN_NONE, 0, 0, 0}
  };

  dead_reckoning_odometry DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // CORDIC rotation on a binary angle of 2^-32 turn, giving cosine and sine in
  // Q1.15. Angles in the back half-plane are turned by half a turn first and
  // the vector is negated afterwards.
  function automatic void sin_cos(input logic [31:0] angle, output longint cos_q15,
                                  output longint sin_q15);
    logic [31:0] a;
    int          a_signed;
    bit          flip;
    longint      x, y, z, dx, dy;
    a = angle;
    flip = 1'b0;
    if (a >= 32'h4000_0000 && a < 32'hc000_0000) begin
      a = a + 32'h8000_0000;
      flip = 1'b1;
    end
    a_signed = int'(a);
    z = longint'(a_signed);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q15 = clamp((x + 16384) >>> 15, -32768, 32767);
    sin_q15 = clamp((y + 16384) >>> 15, -32768, 32767);
  endfunction

  // Distance covered in one step: speed times ticks over 2^10, rounded half
  // away from zero.
  function automatic longint travel(input longint vel, input logic [31:0] dt);
    longint ticks, mag;
    ticks = longint'(dt);
    mag = ((vel < 0) ? -vel : vel) * ticks;
    mag = (mag + 512) >>> 10;
    return (vel < 0) ? -mag : mag;
  endfunction

  // Heading change in 2^-16 turn: rate times ticks times 2^20/(2 pi) over
  // 2^32, with the time split into halves to keep the products in range.
  function automatic longint turn(input longint yaw, input logic [31:0] dt);
    longint ticks, rate, upper, lower, mag;
    ticks = longint'(dt);
    rate = ((yaw < 0) ? -yaw : yaw) * TURN_GAIN;
    upper = rate * (ticks >> 16);
    lower = rate * (ticks & 64'hffff);
    mag = (upper + (lower >> 16) + 32768) >> 16;
    return (yaw < 0) ? -mag : mag;
  endfunction

  // Advances the odometry by one beat and returns the pose the block should
  // publish for it.
  function automatic dro_out_t predict_pose(input dro_in_t beat);
    longint      vel, yaw, c, s, vx, vy, qz, qw;
    logic [31:0] dt;
    logic [31:0] head_bits;
    dro_out_t    pose;
    vel = longint'(beat.linear_velocity);
    yaw = longint'(beat.yaw_rate);
    dt = beat.timestamp - odo_last_time;
    // The velocity is rotated by the heading held before this step.
    head_bits = odo_heading[31:0];
    sin_cos({head_bits[15:0], 16'h0000}, c, s);
    vx = clamp((vel * c + 16384) >>> 15, -32768, 32767);
    vy = clamp((vel * s + 16384) >>> 15, -32768, 32767);
    odo_x = clamp(odo_x + travel(vx, dt), ACC_MIN, ACC_MAX);
    odo_y = clamp(odo_y + travel(vy, dt), ACC_MIN, ACC_MAX);
    odo_heading = clamp(odo_heading + turn(yaw, dt), WORD_MIN, WORD_MAX);
    odo_last_time = beat.timestamp;
    // The quaternion uses half the new heading.
    head_bits = odo_heading[31:0];
    sin_cos({head_bits[16:0], 15'h0000}, qw, qz);
    pose.position_x   = 32'(clamp(odo_x, WORD_MIN, WORD_MAX));
    pose.position_y   = 32'(clamp(odo_y, WORD_MIN, WORD_MAX));
    pose.heading      = odo_heading[31:0];
    pose.quat_z       = 16'(qz);
    pose.quat_w       = 16'(qw);
    pose.velocity_x   = 16'(vx);
    pose.velocity_y   = 16'(vy);
    pose.yaw_rate_out = beat.yaw_rate;
    return pose;
  endfunction

  // Speeds and rates: a share of extremes and small values around zero, the
  // rest spread over the whole 16-bit range.
  function automatic logic signed [15:0] draw_speed();
    case ($urandom_range(19))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      4:       return 16'sd1;
      5, 6:    return 16'($urandom_range(2000)) - 16'sd1000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input longint expected, input longint actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // Presents one beat after a random idle gap and waits for it to be taken.
  // The valid is only lowered when a gap really follows, so it never gets a
  // low and a high assignment within the same time step.
  task automatic send_beat(input dro_in_t beat, input logic [2:0] pin,
                           input longint pin_x, input longint pin_y, input longint pin_h);
    int       gap;
    dro_out_t pose;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    pose = predict_pose(beat);
    if (pin & PIN_X) pose.position_x = 32'(pin_x);
    if (pin & PIN_Y) pose.position_y = 32'(pin_y);
    if (pin & PIN_H) pose.heading = 32'(pin_h);
    pending_poses.push_back(pose);
    last_stamp = beat.timestamp;
  endtask

  // Stops sending until every pose in flight has come back. The task always waits
  // for a clock edge, so the valid is never lowered and raised in one step.
  task automatic hold_off();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_poses.size() != 0);
  endtask

  // The receiver stalls at random; the rate changes from phase to phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // Every result beat is compared with the oldest pose waiting. Inputs all
  // change on nonblocking assignments, so the values seen here are the ones
  // that decided the handshake at this edge.
  always @(posedge clk) begin
    dro_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        $error("result beat with no pose pending");
        error_count++;
      end else begin
        want = pending_poses.pop_front();
        check_field("position_x", longint'(want.position_x),
                    longint'(out_data.position_x));
        check_field("position_y", longint'(want.position_y),
                    longint'(out_data.position_y));
        check_field("heading", longint'(want.heading), longint'(out_data.heading));
        check_field("quat_z", longint'(want.quat_z), longint'(out_data.quat_z));
        check_field("quat_w", longint'(want.quat_w), longint'(out_data.quat_w));
        check_field("velocity_x", longint'(want.velocity_x),
                    longint'(out_data.velocity_x));
        check_field("velocity_y", longint'(want.velocity_y),
                    longint'(out_data.velocity_y));
        check_field("yaw_rate_out", longint'(want.yaw_rate_out),
                    longint'(out_data.yaw_rate_out));
      end
    end
  end

  initial begin
    dro_in_t beat;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats, under a sluggish receiver.
    foreach (drive_plan[i]) begin
      beat.linear_velocity = drive_plan[i].vel;
      beat.yaw_rate        = drive_plan[i].yaw;
      beat.timestamp       = drive_plan[i].stamp;
      send_beat(beat, drive_plan[i].pin, longint'(drive_plan[i].x),
                longint'(drive_plan[i].y), longint'(drive_plan[i].h));
    end
    hold_off();

    // Random beats in three phases: slow receiver, slow sender, then both
    // running flat out. Most steps are short, as from a wheel encoder; some
    // are long, some repeat the timestamp and some jump anywhere, which
    // wraps the time and pushes the pose into saturation now and then.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 31 : (phase == 1) ? 71 : 0;
      receiver_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        beat.linear_velocity = draw_speed();
        beat.yaw_rate        = draw_speed();
        case ($urandom_range(19))
          0:       beat.timestamp = $urandom;
          1:       beat.timestamp = last_stamp;
          2, 3:    beat.timestamp = last_stamp + $urandom_range(1 << 20);
          default: beat.timestamp = last_stamp + $urandom_range(4096);
        endcase
        send_beat(beat, PIN_NONE, 0, 0, 0);
      end
      hold_off();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("dead_reckoning_odometry test passed");
    end else begin
      $display("dead_reckoning_odometry test failed");
    end
    $finish;
  end

  // A watchdog that fails the run if it hangs; it allows well over ten times the
  // length of a correct run before giving up.
  initial begin
    #15_000_000;
    $display("dead_reckoning_odometry test failed");
    $finish;
  end

endmodule
